// ----- hdl/m4ci_pkg.sv -----
package m4ci_pkg;

    // fixed internal word sizes
    localparam int ACC_BITS  = 64;
    localparam int HALF_BITS = 32;
    localparam int PROD_BITS = 128;
    localparam int ADDR_BITS = 6;

    // defaults for the top level parameters
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_WORD_BITS = 32;

    // scratch memory map
    localparam logic [ADDR_BITS-1:0] ADDR_MINOR = 6'd16;
    localparam logic [ADDR_BITS-1:0] ADDR_COF   = 6'd40;
    localparam logic [ADDR_BITS-1:0] ADDR_TEMP  = 6'd56;

    // accumulate operations
    typedef logic [1:0] op_t;
    localparam op_t OP_MUL_LOAD = 2'd0;
    localparam op_t OP_MUL_SUB  = 2'd1;
    localparam op_t OP_MUL_ADD  = 2'd2;
    localparam op_t OP_ADD_MEM  = 2'd3;

    // compute phases
    typedef logic [1:0] phase_t;
    localparam phase_t PH_MINOR = 2'd0;
    localparam phase_t PH_COF   = 2'd1;
    localparam phase_t PH_DET   = 2'd2;

    // one micro-operation of the adjugate/determinant program
    typedef struct packed {
        op_t                  op;
        logic [ADDR_BITS-1:0] a_addr;
        logic [ADDR_BITS-1:0] b_addr;
        logic                 store;
        logic                 negate;
        logic                 to_det;
        logic [ADDR_BITS-1:0] dst_addr;
        logic                 last;
    } uop_t;

    // magnitude of a signed 64-bit word (most negative value maps to 2^63)
    function automatic logic [ACC_BITS-1:0] mag64(input logic [ACC_BITS-1:0] a);
        mag64 = a[ACC_BITS-1] ? (~a + 64'd1) : a;
    endfunction

endpackage

// ----- hdl/m4ci_ucode.sv -----
module m4ci_ucode (
    input  m4ci_pkg::phase_t phase,
    input  logic [4:0]       entry,
    input  logic [2:0]       term,
    output m4ci_pkg::uop_t   uop
);

    logic [1:0] p, q, ci, cj, kk, cc, src_row;
    logic [2:0] grp;
    logic       src;

    // row pair of a minor group
    always_comb begin
        case (entry[4:2])
            3'd0:    begin p = 2'd2; q = 2'd3; end
            3'd1:    begin p = 2'd1; q = 2'd3; end
            3'd2:    begin p = 2'd1; q = 2'd2; end
            3'd3:    begin p = 2'd0; q = 2'd3; end
            3'd4:    begin p = 2'd0; q = 2'd2; end
            3'd5:    begin p = 2'd0; q = 2'd1; end
            default: begin p = 2'd0; q = 2'd0; end
        endcase
    end

    // column pair of a minor
    always_comb begin
        case (entry[1:0])
            2'd0:    begin ci = 2'd2; cj = 2'd3; end
            2'd1:    begin ci = 2'd2; cj = 2'd3; end
            2'd2:    begin ci = 2'd1; cj = 2'd3; end
            default: begin ci = 2'd1; cj = 2'd2; end
        endcase
    end

    // cofactor term: source row and minor group
    assign cc = entry[3:2];
    assign kk = entry[1:0];
    assign src = (kk == 2'd0);
    always_comb begin
        case ({cc, term[1:0]})
            4'b00_00: begin src_row = 2'd1; grp = 3'd0; end
            4'b00_01: begin src_row = 2'd2; grp = 3'd1; end
            4'b00_10: begin src_row = 2'd3; grp = 3'd2; end
            4'b01_00: begin src_row = 2'd0; grp = 3'd0; end
            4'b01_01: begin src_row = 2'd2; grp = 3'd3; end
            4'b01_10: begin src_row = 2'd3; grp = 3'd4; end
            4'b10_00: begin src_row = 2'd0; grp = 3'd1; end
            4'b10_01: begin src_row = 2'd1; grp = 3'd3; end
            4'b10_10: begin src_row = 2'd3; grp = 3'd5; end
            4'b11_00: begin src_row = 2'd0; grp = 3'd2; end
            4'b11_01: begin src_row = 2'd1; grp = 3'd4; end
            4'b11_10: begin src_row = 2'd2; grp = 3'd5; end
            default:  begin src_row = 2'd0; grp = 3'd0; end
        endcase
    end

    // decode
    always_comb begin
        uop = '0;
        case (phase)
            m4ci_pkg::PH_MINOR: begin
                uop.dst_addr = m4ci_pkg::ADDR_MINOR + {1'b0, entry};
                if (term[0] == 1'b0) begin
                    uop.op     = m4ci_pkg::OP_MUL_LOAD;
                    uop.a_addr = {2'b00, ci, p};
                    uop.b_addr = {2'b00, cj, q};
                end else begin
                    uop.op     = m4ci_pkg::OP_MUL_SUB;
                    uop.a_addr = {2'b00, cj, p};
                    uop.b_addr = {2'b00, ci, q};
                    uop.store  = 1'b1;
                    uop.last   = (entry == 5'd23);
                end
            end
            m4ci_pkg::PH_COF: begin
                uop.a_addr   = {2'b00, 1'b0, src, src_row};
                uop.b_addr   = m4ci_pkg::ADDR_MINOR + {1'b0, grp, kk};
                uop.dst_addr = m4ci_pkg::ADDR_COF + {2'b00, entry[3:0]};
                uop.negate   = cc[0] ^ kk[0];
                case (term[1:0])
                    2'd0:    uop.op = m4ci_pkg::OP_MUL_LOAD;
                    2'd1:    uop.op = m4ci_pkg::OP_MUL_SUB;
                    default: begin
                        uop.op    = m4ci_pkg::OP_MUL_ADD;
                        uop.store = 1'b1;
                        uop.last  = (entry[3:0] == 4'd15);
                    end
                endcase
            end
            m4ci_pkg::PH_DET: begin
                uop.dst_addr = m4ci_pkg::ADDR_TEMP;
                uop.a_addr   = {3'b000, term};
                uop.b_addr   = m4ci_pkg::ADDR_COF + {1'b0, term[1:0], 2'b00};
                case (term)
                    3'd0:    uop.op = m4ci_pkg::OP_MUL_LOAD;
                    3'd1:    begin
                        uop.op    = m4ci_pkg::OP_MUL_ADD;
                        uop.store = 1'b1;
                    end
                    3'd2:    uop.op = m4ci_pkg::OP_MUL_LOAD;
                    3'd3:    uop.op = m4ci_pkg::OP_MUL_ADD;
                    default: begin
                        uop.op     = m4ci_pkg::OP_ADD_MEM;
                        uop.a_addr = m4ci_pkg::ADDR_TEMP;
                        uop.to_det = 1'b1;
                        uop.last   = 1'b1;
                    end
                endcase
            end
            default: uop = '0;
        endcase
    end

endmodule

// ----- hdl/m4ci_mul.sv -----
module m4ci_mul #(
    parameter int FRAC_BITS = m4ci_pkg::DEF_FRAC_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [m4ci_pkg::ACC_BITS-1:0]  op_a,
    input  logic [m4ci_pkg::ACC_BITS-1:0]  op_b,
    output logic                           done,
    output logic [m4ci_pkg::ACC_BITS-1:0]  result
);

    localparam int AW = m4ci_pkg::ACC_BITS;
    localparam int HW = m4ci_pkg::HALF_BITS;
    localparam int PW = m4ci_pkg::PROD_BITS;

    logic [AW-1:0] ma_reg, mb_reg;
    logic          neg_reg;
    logic [PW-1:0] prod_reg;
    logic [2:0]    step_reg;
    logic          busy_reg, done_reg;
    logic [AW-1:0] result_reg;

    logic [HW-1:0] ha, hb;
    logic [AW-1:0] pp;
    logic [PW-1:0] pp_sh;
    logic [PW-1:0] q;
    logic          ovf;
    logic [AW-1:0] qs;

    // one 32x32 partial product per step
    assign ha = step_reg[0] ? ma_reg[AW-1:HW] : ma_reg[HW-1:0];
    assign hb = step_reg[1] ? mb_reg[AW-1:HW] : mb_reg[HW-1:0];
    assign pp = ha * hb;

    always_comb begin
        case (step_reg[1:0])
            2'b00:   pp_sh = {{(PW-AW){1'b0}}, pp};
            2'b11:   pp_sh = {pp, {AW{1'b0}}};
            default: pp_sh = {{(PW-AW-HW){1'b0}}, pp, {HW{1'b0}}};
        endcase
    end

    // round half away from zero on the magnitude, then saturate
    assign q = (prod_reg >> FRAC_BITS) + {{(PW-1){1'b0}}, prod_reg[FRAC_BITS-1]};
    assign ovf = neg_reg ? ((q[PW-1:AW] != '0) || (q[AW-1] && (q[AW-2:0] != '0)))
                         : (q[PW-1:AW-1] != '0);
    assign qs = ovf ? (neg_reg ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}})
                    : q[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg   <= m4ci_pkg::mag64(op_a);
            mb_reg   <= m4ci_pkg::mag64(op_b);
            neg_reg  <= op_a[AW-1] ^ op_b[AW-1];
            prod_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg == 3'd4) begin
                result_reg <= neg_reg ? (~qs + 64'd1) : qs;
            end else begin
                prod_reg <= prod_reg + pp_sh;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- hdl/m4ci_div.sv -----
module m4ci_div #(
    parameter int FRAC_BITS = m4ci_pkg::DEF_FRAC_BITS,
    parameter int WORD_BITS = m4ci_pkg::DEF_WORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [m4ci_pkg::ACC_BITS-1:0]  num,
    input  logic [m4ci_pkg::ACC_BITS-1:0]  den,
    output logic                           done,
    output logic [WORD_BITS-1:0]           quotient
);

    localparam int AW = m4ci_pkg::ACC_BITS;
    localparam int PW = m4ci_pkg::PROD_BITS;

    logic [AW-1:0]        ud_reg, rem_reg;
    logic [PW-1:0]        num_reg, quo_reg;
    logic [6:0]           cnt_reg;
    logic                 neg_reg, busy_reg, fin_reg, done_reg;
    logic [WORD_BITS-1:0] quotient_reg;

    logic [AW-1:0]  rem_sh;
    logic           take;
    logic [PW-1:0]  q_rnd, one_w, lim, q_sat;

    // one restoring step per cycle
    assign rem_sh = {rem_reg[AW-2:0], num_reg[PW-1]};
    assign take   = rem_reg[AW-1] || (rem_sh >= ud_reg);

    // round half away from zero, saturate to the output word
    assign q_rnd = quo_reg + {{(PW-1){1'b0}}, (rem_reg >= (ud_reg - rem_reg))};
    assign one_w = {{(PW-1){1'b0}}, 1'b1} << (WORD_BITS - 1);
    assign lim   = neg_reg ? one_w : (one_w - {{(PW-1){1'b0}}, 1'b1});
    assign q_sat = (q_rnd > lim) ? lim : q_rnd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
                cnt_reg  <= 7'd0;
            end else if (busy_reg) begin
                if (fin_reg) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    if (cnt_reg == 7'd127) begin
                        fin_reg <= 1'b1;
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            ud_reg  <= m4ci_pkg::mag64(den);
            num_reg <= {{(PW-AW){1'b0}}, m4ci_pkg::mag64(num)} << FRAC_BITS;
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= num[AW-1] ^ den[AW-1];
        end else if (busy_reg) begin
            if (fin_reg) begin
                quotient_reg <= neg_reg ? (~q_sat[WORD_BITS-1:0] + {{(WORD_BITS-1){1'b0}}, 1'b1})
                                        : q_sat[WORD_BITS-1:0];
            end else begin
                num_reg <= {num_reg[PW-2:0], 1'b0};
                rem_reg <= take ? (rem_sh - ud_reg) : rem_sh;
                quo_reg <= {quo_reg[PW-2:0], take};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

// ----- hdl/matrix4_cofactor_inverse_unit.sv -----
// 4x4 matrix inverse by cofactors, signed fixed point with FRAC_BITS fraction bits.
// Sixteen elements are taken one per cycle in column-major order; the unit then
// runs 101 accumulate steps (24 minors, 16 cofactors, the determinant) on one
// shared 64-bit multiplier built from four 32x32 partial products, and then 16
// divisions on a bit-serial restoring divider, one inverse element per division;
// s_ready stays low from the sixteenth element until the last result has been
// handed to the output register. A zero determinant raises m_singular on all
// sixteen results with zero values and skips the divisions.
module matrix4_cofactor_inverse_unit #(
    parameter int FRAC_BITS = m4ci_pkg::DEF_FRAC_BITS,
    parameter int WORD_BITS = m4ci_pkg::DEF_WORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_BITS-1:0] s_element,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_BITS-1:0] m_value,
    output logic [1:0]           m_column,
    output logic [1:0]           m_row,
    output logic                 m_last,
    output logic                 m_singular
);

    localparam int AW = m4ci_pkg::ACC_BITS;
    localparam int MW = m4ci_pkg::ADDR_BITS;

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_ISSUE     = 4'd1;
    localparam logic [3:0] S_OPER      = 4'd2;
    localparam logic [3:0] S_MUL       = 4'd3;
    localparam logic [3:0] S_FIN       = 4'd4;
    localparam logic [3:0] S_DIV_ISSUE = 4'd5;
    localparam logic [3:0] S_DIV_START = 4'd6;
    localparam logic [3:0] S_DIV_RUN   = 4'd7;
    localparam logic [3:0] S_DIV_OUT   = 4'd8;

    localparam logic [AW-1:0] SAT_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic [AW-1:0] SAT_MIN = {1'b1, {(AW-1){1'b0}}};

    logic [3:0]             state_reg, state_next;
    logic [3:0]             load_cnt_reg, load_cnt_next;
    m4ci_pkg::phase_t       phase_reg, phase_next;
    logic [4:0]             entry_reg, entry_next;
    logic [2:0]             term_reg, term_next;
    logic [3:0]             k_reg, k_next;
    logic [AW-1:0]          acc_reg, acc_next;
    logic [AW-1:0]          det_reg;
    logic                   sing_reg;

    logic                   m_valid_reg;
    logic [WORD_BITS-1:0]   m_value_reg;
    logic [1:0]             m_column_reg, m_row_reg;
    logic                   m_last_reg, m_singular_reg;

    logic [AW-1:0]          mem [2**MW];
    logic [AW-1:0]          rd_a_reg, rd_b_reg;
    logic [MW-1:0]          rd_a_addr;
    logic                   wr_en;
    logic [MW-1:0]          wr_addr;
    logic [AW-1:0]          wr_data;

    m4ci_pkg::uop_t         uop;
    logic                   mul_start, mul_done;
    logic [AW-1:0]          mul_res;
    logic                   div_start, div_done;
    logic [WORD_BITS-1:0]   div_res;
    logic [2:0]             term_max;
    logic                   out_free, in_acc, out_load;
    logic [AW-1:0]          addend;

    function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] != s[AW-1]) sat_add = s[AW] ? SAT_MIN : SAT_MAX;
        else                  sat_add = s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] sat_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {a[AW-1], a} - {b[AW-1], b};
        if (s[AW] != s[AW-1]) sat_sub = s[AW] ? SAT_MIN : SAT_MAX;
        else                  sat_sub = s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] sat_neg(input logic [AW-1:0] a);
        sat_neg = (a == SAT_MIN) ? SAT_MAX : (~a + 64'd1);
    endfunction

    // program decode
    m4ci_ucode u_ucode (
        .phase (phase_reg),
        .entry (entry_reg),
        .term  (term_reg),
        .uop   (uop)
    );

    // shared multiplier
    m4ci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (rd_a_reg),
        .op_b    (rd_b_reg),
        .done    (mul_done),
        .result  (mul_res)
    );

    // divider
    m4ci_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (rd_a_reg),
        .den      (det_reg),
        .done     (div_done),
        .quotient (div_res)
    );

    assign s_ready   = (state_reg == S_LOAD);
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == S_DIV_OUT) && out_free;
    assign mul_start = (state_reg == S_OPER) && (uop.op != m4ci_pkg::OP_ADD_MEM);
    assign div_start = (state_reg == S_DIV_START) && !sing_reg;
    assign rd_a_addr = (state_reg == S_DIV_ISSUE) ? (m4ci_pkg::ADDR_COF + {2'b00, k_reg})
                                                  : uop.a_addr;

    // accumulate step
    assign addend = (uop.op == m4ci_pkg::OP_ADD_MEM) ? rd_a_reg : mul_res;
    always_comb begin
        case (uop.op)
            m4ci_pkg::OP_MUL_LOAD: acc_next = mul_res;
            m4ci_pkg::OP_MUL_SUB:  acc_next = sat_sub(acc_reg, mul_res);
            default:               acc_next = sat_add(acc_reg, addend);
        endcase
    end

    always_comb begin
        case (phase_reg)
            m4ci_pkg::PH_MINOR: term_max = 3'd1;
            m4ci_pkg::PH_COF:   term_max = 3'd2;
            default:            term_max = 3'd4;
        endcase
    end

    // scratch memory write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = uop.dst_addr;
        wr_data = uop.negate ? sat_neg(acc_next) : acc_next;
        if (in_acc) begin
            wr_en   = 1'b1;
            wr_addr = {2'b00, load_cnt_reg};
            wr_data = {{(AW-WORD_BITS){s_element[WORD_BITS-1]}}, s_element};
        end else if ((state_reg == S_FIN) && uop.store) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[uop.b_addr];
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        phase_next    = phase_reg;
        entry_next    = entry_reg;
        term_next     = term_reg;
        k_next        = k_reg;
        case (state_reg)
            S_LOAD: begin
                if (in_acc) begin
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == 4'd15) begin
                        state_next = S_ISSUE;
                        phase_next = m4ci_pkg::PH_MINOR;
                        entry_next = 5'd0;
                        term_next  = 3'd0;
                    end
                end
            end
            S_ISSUE: state_next = S_OPER;
            S_OPER: begin
                state_next = (uop.op == m4ci_pkg::OP_ADD_MEM) ? S_FIN : S_MUL;
            end
            S_MUL: begin
                if (mul_done) state_next = S_FIN;
            end
            S_FIN: begin
                state_next = S_ISSUE;
                if (uop.last) begin
                    entry_next = 5'd0;
                    term_next  = 3'd0;
                    case (phase_reg)
                        m4ci_pkg::PH_MINOR: phase_next = m4ci_pkg::PH_COF;
                        m4ci_pkg::PH_COF:   phase_next = m4ci_pkg::PH_DET;
                        default: begin
                            state_next = S_DIV_ISSUE;
                            k_next     = 4'd0;
                        end
                    endcase
                end else if (term_reg == term_max) begin
                    term_next  = 3'd0;
                    entry_next = entry_reg + 5'd1;
                end else begin
                    term_next = term_reg + 3'd1;
                end
            end
            S_DIV_ISSUE: state_next = S_DIV_START;
            S_DIV_START: state_next = sing_reg ? S_DIV_OUT : S_DIV_RUN;
            S_DIV_RUN: begin
                if (div_done) state_next = S_DIV_OUT;
            end
            S_DIV_OUT: begin
                if (out_free) begin
                    k_next     = k_reg + 4'd1;
                    state_next = (k_reg == 4'd15) ? S_LOAD : S_DIV_ISSUE;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= 4'd0;
            phase_reg    <= m4ci_pkg::PH_MINOR;
            entry_reg    <= 5'd0;
            term_reg     <= 3'd0;
            k_reg        <= 4'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            phase_reg    <= phase_next;
            entry_reg    <= entry_next;
            term_reg     <= term_next;
            k_reg        <= k_next;
            if (out_load)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // accumulator, determinant and output register
    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN) begin
            acc_reg <= acc_next;
            if (uop.to_det) begin
                det_reg  <= acc_next;
                sing_reg <= (acc_next == '0);
            end
        end
        if (out_load) begin
            m_value_reg    <= sing_reg ? '0 : div_res;
            m_column_reg   <= k_reg[3:2];
            m_row_reg      <= k_reg[1:0];
            m_last_reg     <= (k_reg == 4'd15);
            m_singular_reg <= sing_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_value    = m_value_reg;
    assign m_column   = m_column_reg;
    assign m_row      = m_row_reg;
    assign m_last     = m_last_reg;
    assign m_singular = m_singular_reg;

`ifndef NO_ASSERTIONS
    // a partly loaded matrix keeps the unit in the load state
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_cnt_reg != 4'd0) |-> (state_reg == S_LOAD))
        else $error("partial load outside load state");

    // singular results carry zero values
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_singular) |-> (m_value == '0))
        else $error("singular result with nonzero value");

    // last marks the bottom-right element
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> ((m_row == 2'd3) && (m_column == 2'd3)))
        else $error("last on wrong element");

    // divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV_RUN))
        else $error("unexpected divider completion");

    // multiplier finishes only while the sequencer waits for it
    a_mul_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_MUL))
        else $error("unexpected multiplier completion");
`endif

endmodule
